[src/rrph_pkg.sv]
// Shared types, constants and the CORDIC angle table of the rotated-rectangle hit test.
`timescale 1ns / 1ps
`default_nettype none

package rrph_pkg;

  // Field and register widths.
  localparam int CoordW   = 20;
  localparam int CenterW  = 20;
  localparam int SizeW    = 19;
  localparam int AngleW   = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // Corner storage: x and y of the four corners.
  localparam int CornerW    = 22;
  localparam int NumCorners = 4;
  localparam int NumCoords  = 2 * NumCorners;

  // Point datapath widths.
  localparam int DiffW   = CornerW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int CrossW  = ProdW + 1;
  localparam int AbsW    = ProdW;
  localparam int SumW    = AbsW + 2;
  localparam int AreaW   = SumW;
  localparam int TolDiv  = 1000;
  localparam int TolW    = $clog2(TolDiv + 1);
  localparam int ScaledW = SumW + TolW;

  // Sine and cosine generation.
  localparam int TrigW       = 27;
  localparam int ZW          = 24;
  localparam int ZScaleShift = 8;
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int CordicGain  = 10188014;
  localparam int FoldW       = AngleW + 1;
  localparam int FullTurn    = 46080;
  localparam int HalfTurn    = 23040;
  localparam int QuarterTurn = 11520;

  // Shared multiplier and corner rounding.
  localparam int MulW       = TrigW;
  localparam int MulOutW    = 2 * MulW;
  localparam int OffW       = ProdW + 1;
  localparam int CornerFrac = 25;
  localparam int RoundHalf  = 1 << (CornerFrac - 1);

  // Positions of the corner coordinates.
  localparam int LtX = 0;
  localparam int LtY = 1;
  localparam int LbX = 2;
  localparam int LbY = 3;
  localparam int RtX = 4;
  localparam int RtY = 5;
  localparam int RbX = 6;
  localparam int RbY = 7;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_WIDTH     = 3'd2,
    CFG_HEIGHT    = 3'd3,
    CFG_ANGLE     = 3'd4
  } cfg_idx_e;

  // Derived rectangle geometry handed to the point datapath.
  typedef struct packed {
    logic [NumCoords-1:0][CornerW-1:0] coord;
    logic [AreaW-1:0]                  area;
  } geom_t;

  // Arctangent of 2^-i in units of 1/32768 degree.
  function automatic logic signed [ZW-1:0] atan_step(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(1474560);
      1:       val = ZW'(870484);
      2:       val = ZW'(459940);
      3:       val = ZW'(233473);
      4:       val = ZW'(117189);
      5:       val = ZW'(58652);
      6:       val = ZW'(29333);
      7:       val = ZW'(14667);
      8:       val = ZW'(7334);
      9:       val = ZW'(3667);
      10:      val = ZW'(1833);
      11:      val = ZW'(917);
      12:      val = ZW'(458);
      13:      val = ZW'(229);
      14:      val = ZW'(115);
      default: val = ZW'(57);
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[src/rrph_geom.sv]
// Configuration registers and the sequencer that derives the corners and area.
`timescale 1ns / 1ps
`default_nettype none

module rrph_geom import rrph_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                busy_o,
  output geom_t               geom_o
);

  localparam int NumProd   = 4;
  localparam int AreaSteps = 6;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_CORDIC = 6'b000100,
    ST_PROD   = 6'b001000,
    ST_CORNER = 6'b010000,
    ST_AREA   = 6'b100000
  } geom_state_e;

  logic signed [CenterW-1:0] center_x_q, center_y_q;
  logic [SizeW-1:0]          width_q, height_q;
  logic signed [AngleW-1:0]  angle_q;

  geom_state_e      state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  logic signed [TrigW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]      z_q;
  logic                      neg_q;
  logic signed [ProdW-1:0]   wc_q, hs_q, hc_q, ws_q;
  logic signed [CornerW-1:0] corner_q [NumCoords];
  logic signed [ProdW-1:0]   prod_q;
  logic signed [CrossW-1:0]  cr_q;
  logic [AreaW-1:0]          area_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      angle_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_X: center_x_q <= $signed(cfg_wdata_i[CenterW-1:0]);
        CFG_CENTER_Y: center_y_q <= $signed(cfg_wdata_i[CenterW-1:0]);
        CFG_WIDTH:    width_q    <= cfg_wdata_i[SizeW-1:0];
        CFG_HEIGHT:   height_q   <= cfg_wdata_i[SizeW-1:0];
        CFG_ANGLE:    angle_q    <= $signed(cfg_wdata_i[AngleW-1:0]);
        default: ;
      endcase
    end
  end

  // Angle folding into +-90 degrees, with the sign flip noted for later.
  logic signed [FoldW-1:0] ang_ext, ang_wrap, ang_fold;
  logic                    fold_neg;
  logic signed [ZW-1:0]    z_init;

  always_comb begin
    ang_ext = FoldW'(angle_q);
    if (ang_ext > FoldW'(HalfTurn)) begin
      ang_wrap = ang_ext - FoldW'(FullTurn);
    end else if (ang_ext <= -FoldW'(HalfTurn)) begin
      ang_wrap = ang_ext + FoldW'(FullTurn);
    end else begin
      ang_wrap = ang_ext;
    end
    fold_neg = 1'b1;
    if (ang_wrap > FoldW'(QuarterTurn)) begin
      ang_fold = ang_wrap - FoldW'(HalfTurn);
    end else if (ang_wrap < -FoldW'(QuarterTurn)) begin
      ang_fold = ang_wrap + FoldW'(HalfTurn);
    end else begin
      ang_fold = ang_wrap;
      fold_neg = 1'b0;
    end
    z_init = ZW'(ang_fold) <<< ZScaleShift;
  end

  // One CORDIC rotation per cycle.
  logic signed [TrigW-1:0] x_sh, y_sh, x_step, y_step;
  logic signed [ZW-1:0]    z_step;

  always_comb begin
    x_sh = x_q >>> cnt_q;
    y_sh = y_q >>> cnt_q;
    if (!z_q[ZW-1]) begin
      x_step = x_q - y_sh;
      y_step = y_q + x_sh;
      z_step = z_q - atan_step(cnt_q);
    end else begin
      x_step = x_q + y_sh;
      y_step = y_q - x_sh;
      z_step = z_q + atan_step(cnt_q);
    end
  end

  // Shared multiplier: size times trig terms, then the corner cross products.
  logic signed [TrigW-1:0]   cos_v, sin_v;
  logic signed [MulW-1:0]    width_s, height_s;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [MulOutW-1:0] mul_p;
  logic signed [ProdW-1:0]   prod_v;

  always_comb begin
    cos_v    = neg_q ? -x_q : x_q;
    sin_v    = neg_q ? -y_q : y_q;
    width_s  = $signed(MulW'(width_q));
    height_s = $signed(MulW'(height_q));
    if (state_q == ST_PROD) begin
      case (cnt_q[1:0])
        2'd0: begin mul_a = width_s;  mul_b = cos_v; end
        2'd1: begin mul_a = height_s; mul_b = sin_v; end
        2'd2: begin mul_a = height_s; mul_b = cos_v; end
        default: begin mul_a = width_s; mul_b = sin_v; end
      endcase
    end else begin
      case (cnt_q[1:0])
        2'd0: begin
          mul_a = MulW'(corner_q[LbX]) - MulW'(corner_q[LtX]);
          mul_b = MulW'(corner_q[RtY]) - MulW'(corner_q[LtY]);
        end
        2'd1: begin
          mul_a = MulW'(corner_q[LbY]) - MulW'(corner_q[LtY]);
          mul_b = MulW'(corner_q[RtX]) - MulW'(corner_q[LtX]);
        end
        2'd2: begin
          mul_a = MulW'(corner_q[RtX]) - MulW'(corner_q[LbX]);
          mul_b = MulW'(corner_q[RbY]) - MulW'(corner_q[LbY]);
        end
        default: begin
          mul_a = MulW'(corner_q[RtY]) - MulW'(corner_q[LbY]);
          mul_b = MulW'(corner_q[RbX]) - MulW'(corner_q[LbX]);
        end
      endcase
    end
    mul_p  = MulOutW'(mul_a) * MulOutW'(mul_b);
    prod_v = ProdW'(mul_p);
  end

  // One corner coordinate per cycle: signed sum of two products, rounded, plus center.
  logic [1:0]              corner_n;
  logic                    is_y, sx_pos, sy_pos;
  logic signed [ProdW-1:0] term1, term2;
  logic signed [OffW-1:0]  off_sum, off, ctr;
  logic signed [CornerW-1:0] corner_val;

  always_comb begin
    corner_n = cnt_q[2:1];
    is_y     = cnt_q[0];
    sx_pos   = corner_n[1];
    sy_pos   = !corner_n[0];
    if (!is_y) begin
      term1 = sx_pos ? wc_q : -wc_q;
      term2 = sy_pos ? -hs_q : hs_q;
      ctr   = OffW'(center_x_q);
    end else begin
      term1 = sy_pos ? hc_q : -hc_q;
      term2 = sx_pos ? ws_q : -ws_q;
      ctr   = OffW'(center_y_q);
    end
    off_sum    = OffW'(term1) + OffW'(term2) + OffW'(RoundHalf);
    off        = off_sum >>> CornerFrac;
    corner_val = CornerW'(off + ctr);
  end

  // Magnitude of the current cross product.
  logic [AreaW-1:0] cr_abs;

  always_comb begin
    cr_abs = cr_q[CrossW-1] ? AreaW'(-cr_q) : AreaW'(cr_q);
  end

  // Sequencer: start, CORDIC, products, corners, area.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + StepW'(1);
    case (state_q)
      ST_IDLE: cnt_d = '0;
      ST_START: begin
        state_d = ST_CORDIC;
        cnt_d   = '0;
      end
      ST_CORDIC: begin
        if (cnt_q == StepW'(CordicSteps - 1)) begin
          state_d = ST_PROD;
          cnt_d   = '0;
        end
      end
      ST_PROD: begin
        if (cnt_q == StepW'(NumProd - 1)) begin
          state_d = ST_CORNER;
          cnt_d   = '0;
        end
      end
      ST_CORNER: begin
        if (cnt_q == StepW'(NumCoords - 1)) begin
          state_d = ST_AREA;
          cnt_d   = '0;
        end
      end
      ST_AREA: begin
        if (cnt_q == StepW'(AreaSteps - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_START;
        cnt_d   = '0;
      end
    endcase
    // Any write starts the derivation over from the current registers.
    if (cfg_we_i) begin
      state_d = ST_START;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Geometry datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_START: begin
        x_q   <= TrigW'(CordicGain);
        y_q   <= '0;
        z_q   <= z_init;
        neg_q <= fold_neg;
      end
      ST_CORDIC: begin
        x_q <= x_step;
        y_q <= y_step;
        z_q <= z_step;
      end
      ST_PROD: begin
        case (cnt_q[1:0])
          2'd0:    wc_q <= prod_v;
          2'd1:    hs_q <= prod_v;
          2'd2:    hc_q <= prod_v;
          default: ws_q <= prod_v;
        endcase
      end
      ST_CORNER: corner_q[cnt_q[2:0]] <= corner_val;
      ST_AREA: begin
        // Products are issued in steps 0 to 3, registered in prod_q and consumed in steps 1 to 4.
        prod_q <= prod_v;
        case (cnt_q)
          1: cr_q <= CrossW'(prod_q);
          2: cr_q <= cr_q - CrossW'(prod_q);
          3: begin
            area_q <= cr_abs;
            cr_q   <= CrossW'(prod_q);
          end
          4: cr_q <= cr_q - CrossW'(prod_q);
          5: area_q <= area_q + cr_abs;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Outputs.
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    for (int k = 0; k < NumCoords; k++) begin
      geom_o.coord[k] = corner_q[k];
    end
    geom_o.area = area_q;
  end

endmodule

`default_nettype wire

[src/rrph_hit_pipe.sv]
// Six-stage point pipeline: triangle areas, area sum and tolerance compare.
`timescale 1ns / 1ps
`default_nettype none

module rrph_hit_pipe import rrph_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     hold_i,
  input  geom_t                    geom_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     inside_res_o
);

  localparam int NumStages = 6;
  localparam int NumTri    = 4;

  // Triangle edges by corner number: LT, LB, RT, RB are 0 to 3.
  localparam int TriA [NumTri] = '{0, 0, 2, 1};
  localparam int TriB [NumTri] = '{1, 2, 3, 3};

  logic [NumStages:1] vld_q;
  logic [NumStages:1] en;
  logic               accept;

  // A stage may load when it is empty or its successor moves on.
  always_comb begin
    en[NumStages] = !vld_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = hold_i || !en[1];
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= accept;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: corner offsets from the point.
  logic signed [DiffW-1:0] dx_d [NumCorners];
  logic signed [DiffW-1:0] dy_d [NumCorners];
  logic signed [DiffW-1:0] dx_q [NumCorners];
  logic signed [DiffW-1:0] dy_q [NumCorners];

  always_comb begin
    for (int c = 0; c < NumCorners; c++) begin
      dx_d[c] = DiffW'($signed(geom_i.coord[2*c]))   - DiffW'(point_x_i);
      dy_d[c] = DiffW'($signed(geom_i.coord[2*c+1])) - DiffW'(point_y_i);
    end
  end

  // Stage 2: the two products of each triangle's cross product.
  logic signed [ProdW-1:0] pa_d [NumTri];
  logic signed [ProdW-1:0] pb_d [NumTri];
  logic signed [ProdW-1:0] pa_q [NumTri];
  logic signed [ProdW-1:0] pb_q [NumTri];

  always_comb begin
    for (int t = 0; t < NumTri; t++) begin
      pa_d[t] = ProdW'(dx_q[TriA[t]]) * ProdW'(dy_q[TriB[t]]);
      pb_d[t] = ProdW'(dy_q[TriA[t]]) * ProdW'(dx_q[TriB[t]]);
    end
  end

  // Stage 3: doubled triangle areas.
  logic signed [CrossW-1:0] cr_v [NumTri];
  logic [AbsW-1:0]          abs_d [NumTri];
  logic [AbsW-1:0]          abs_q [NumTri];

  always_comb begin
    for (int t = 0; t < NumTri; t++) begin
      cr_v[t]  = CrossW'(pa_q[t]) - CrossW'(pb_q[t]);
      abs_d[t] = cr_v[t][CrossW-1] ? AbsW'(-cr_v[t]) : AbsW'(cr_v[t]);
    end
  end

  // Stage 4: sum of the four triangles.
  logic [SumW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = (SumW'(abs_q[0]) + SumW'(abs_q[1])) + (SumW'(abs_q[2]) + SumW'(abs_q[3]));
  end

  // Stage 5: distance from the rectangle area.
  logic [SumW-1:0] diff_d, diff_q;

  always_comb begin
    if (sum_q >= SumW'(geom_i.area)) begin
      diff_d = sum_q - SumW'(geom_i.area);
    end else begin
      diff_d = SumW'(geom_i.area) - sum_q;
    end
  end

  // Stage 6: tolerance test; the scaled distance always fits, so no overflow case.
  logic res_d, res_q;

  always_comb begin
    res_d = (ScaledW'(diff_q) * ScaledW'(TolDiv)) < ScaledW'(geom_i.area);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (en[2]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (en[3]) begin
      abs_q <= abs_d;
    end
    if (en[4]) begin
      sum_q <= sum_d;
    end
    if (en[5]) begin
      diff_q <= diff_d;
    end
    if (en[6]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = vld_q[NumStages];
  assign inside_res_o = res_q;

endmodule

`default_nettype wire

[src/rotated_rect_point_hit_test_core.sv]
// Top level of the rotated-rectangle point hit test.
`timescale 1ns / 1ps
`default_nettype none

// Tests query points against a rotated rectangle by the area-sum method. The
// rectangle is set by five registers (center, width, height, angle); from them a
// sequencer derives the four corners and the doubled rectangle area, using one
// CORDIC stage stepped sixteen times and one shared multiplier. The input is
// stalled while that derivation runs after reset or after the last configuration
// write, and during the write cycle itself. Then the block takes one point per
// cycle while the output is not stalled and returns one flag per point through
// the six-stage point pipeline, whose stages each hold multiplies, adds or
// compares. The flag is set when the four point-edge triangles add up to the
// rectangle area within one part in a thousand. Stages hold their items while
// the output is stalled, so points keep entering until the pipeline is full.
module rotated_rect_point_hit_test_core import rrph_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     inside_res_o
);

  geom_t geom;
  logic  geom_busy;
  logic  hold;

  // Corner and area derivation from the configuration.
  rrph_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (geom_busy),
    .geom_o      (geom)
  );

  // Points wait while the geometry is being rebuilt.
  assign hold = geom_busy || cfg_we_i;

  // Per-point area test.
  rrph_hit_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (hold),
    .geom_i       (geom),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o)
  );

endmodule

`default_nettype wire
